/* hdl/sfr_pkg.sv */
// Shared widths, constants and sideband types for the Schlick Fresnel reflectance core.
// No dependencies; every other file of the block imports this package.
package sfr_pkg;

    // Q.30 working format; values up to and including 1.0 need 31 bits.
    localparam int FRAC   = 30;
    localparam int CW     = FRAC + 1;
    localparam logic [CW-1:0] ONE_Q30 = CW'(1) << FRAC;
    localparam logic [15:0]   ONE_Q15 = 16'h8000;

    // Divider operand widths and quotient width.
    localparam int NUMW  = 62;
    localparam int SDENW = 32;
    localparam int RDENW = 34;
    localparam int QW    = CW;

    // Pipeline depths of the four sections.
    localparam int FRONT_STG = 5;
    localparam int DIV_STG   = QW;
    localparam int SQRT_STG  = CW;
    localparam int BACK_STG  = 6;
    localparam int LAT       = FRONT_STG + DIV_STG + SQRT_STG + BACK_STG;

    // Sideband carried through the dividers.
    typedef struct packed {
        logic          flag;
        logic          gt;
        logic [CW-1:0] cosv;
    } t_frt;

    // Sideband carried through the square root.
    typedef struct packed {
        logic          flag;
        logic          gt;
        logic [CW-1:0] cosv;
        logic [CW-1:0] r0;
    } t_sqt;

endpackage

/* hdl/schlick_fresnel_reflectance_core.sv */
// Schlick Fresnel reflectance core, top level.
// Instantiates sfr_front, sfr_div, sfr_sqrt and sfr_back; uses sfr_pkg.
//
// Usage:
//   A transaction enters when start is high and busy is low. busy is never
//   raised, so one transaction may enter on every clock cycle. Each carries
//   an eye vector and a normal vector (signed Q2.14) and the indices of the
//   two media (unsigned Q4.12).
//   Exactly one result leaves per transaction, in order: o_valid is high
//   for one cycle together with o_reflectance (Q1.15, 0x8000 is 1.0)
//   and o_total_internal.
//   Throughput is one transaction per cycle; the pipeline is made of the
//   front end (5 stages), the two lockstep dividers (31 stages, one quotient
//   bit each), the square root (31 stages, one root bit each) and the back
//   end (6 stages: four power multiplies, the blend multiply and the
//   rounding stage).
//   The receiver cannot stall, so nothing is ever held back inside.
//   A synchronous reset (i_rst_n low) clears every valid bit; transactions
//   in flight are dropped and no result appears for them.
module schlick_fresnel_reflectance_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [15:0] i_eye_x,
    input  logic signed [15:0] i_eye_y,
    input  logic signed [15:0] i_eye_z,
    input  logic signed [15:0] i_normal_x,
    input  logic signed [15:0] i_normal_y,
    input  logic signed [15:0] i_normal_z,
    input  logic [15:0]        i_index_from,
    input  logic [15:0]        i_index_to,
    output logic               o_valid,
    output logic [15:0]        o_reflectance,
    output logic               o_total_internal
);
    import sfr_pkg::*;

    // The pipeline never stalls, so it can always take a new transaction.
    assign busy = 1'b0;

    logic             f_vld;
    t_frt             f_side;
    logic [NUMW-1:0]  f_snum, f_rnum;
    logic [SDENW-1:0] f_sden;
    logic [RDENW-1:0] f_rden;

    // Dot product, clamp, squares and the total internal reflection test.
    sfr_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_vld        (start && !busy),
        .i_eye_x      (i_eye_x),
        .i_eye_y      (i_eye_y),
        .i_eye_z      (i_eye_z),
        .i_normal_x   (i_normal_x),
        .i_normal_y   (i_normal_y),
        .i_normal_z   (i_normal_z),
        .i_index_from (i_index_from),
        .i_index_to   (i_index_to),
        .o_vld        (f_vld),
        .o_side       (f_side),
        .o_snum       (f_snum),
        .o_sden       (f_sden),
        .o_rnum       (f_rnum),
        .o_rden       (f_rden)
    );

    logic          d_vld;
    t_frt          d_side;
    logic [QW-1:0] d_sin2, d_r0;

    // sin^2 and r0 are divided side by side. When the flag is set or the
    // indices are not in the bending order the sin^2 quotient is ignored.
    sfr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (f_vld),
        .i_side  (f_side),
        .i_snum  (f_snum),
        .i_sden  (f_sden),
        .i_rnum  (f_rnum),
        .i_rden  (f_rden),
        .o_vld   (d_vld),
        .o_side  (d_side),
        .o_sin2  (d_sin2),
        .o_r0    (d_r0)
    );

    t_sqt          q_in, q_side;
    logic          q_vld;
    logic [CW-1:0] q_root, b_cos;

    assign q_in.flag = d_side.flag;
    assign q_in.gt   = d_side.gt;
    assign q_in.cosv = d_side.cosv;
    assign q_in.r0   = d_r0;

    // The refracted cosine sqrt(1 - sin^2).
    sfr_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (d_vld),
        .i_side  (q_in),
        .i_sin2  (d_sin2),
        .o_vld   (q_vld),
        .o_side  (q_side),
        .o_root  (q_root)
    );

    // Only light leaving the denser medium uses the refracted cosine.
    assign b_cos = q_side.gt ? q_root : q_side.cosv;

    sfr_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_vld            (q_vld),
        .i_flag           (q_side.flag),
        .i_cosv           (b_cos),
        .i_r0             (q_side.r0),
        .o_valid          (o_valid),
        .o_reflectance    (o_reflectance),
        .o_total_internal (o_total_internal)
    );

    // A forced result is always exactly 1.0.
    a_flag_is_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_total_internal |-> o_reflectance == ONE_Q15)
        else $error("forced result is not 1.0");

    // The saturation keeps every result at or below 1.0.
    a_saturated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_reflectance <= ONE_Q15)
        else $error("reflectance above 1.0");

    // Every accepted transaction gives a result.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |-> ##LAT o_valid)
        else $error("result missing at fixed latency");

    // No result appears without an earlier transaction.
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, LAT))
        else $error("result without a transaction");

endmodule

/* hdl/sfr_front.sv */
// Front end: dot product, clamp, index squares, sin^2 numerator and the
// total internal reflection test. Five register stages. Uses sfr_pkg.
module sfr_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_vld,
    input  logic signed [15:0]        i_eye_x,
    input  logic signed [15:0]        i_eye_y,
    input  logic signed [15:0]        i_eye_z,
    input  logic signed [15:0]        i_normal_x,
    input  logic signed [15:0]        i_normal_y,
    input  logic signed [15:0]        i_normal_z,
    input  logic [15:0]               i_index_from,
    input  logic [15:0]               i_index_to,
    output logic                      o_vld,
    output sfr_pkg::t_frt             o_side,
    output logic [sfr_pkg::NUMW-1:0]  o_snum,
    output logic [sfr_pkg::SDENW-1:0] o_sden,
    output logic [sfr_pkg::NUMW-1:0]  o_rnum,
    output logic [sfr_pkg::RDENW-1:0] o_rden
);
    import sfr_pkg::*;

    localparam logic [61:0] ONE_Q60 = 62'h1 << 60;
    localparam logic signed [33:0] DOT_ONE = 34'sd268435456;

    // Stage 1 registers.
    logic               r1_vld;
    logic signed [31:0] r1_px, r1_py, r1_pz;
    logic [15:0]        r1_n1, r1_n2, r1_d;
    logic [16:0]        r1_s;
    logic               r1_zero, r1_gt;
    // Stage 2 registers.
    logic               r2_vld;
    logic [CW-1:0]      r2_cos;
    logic [15:0]        r2_n1, r2_n2;
    logic               r2_zero, r2_gt;
    logic [SDENW-1:0]   r2_dsq;
    logic [RDENW-1:0]   r2_ssq;
    // Stage 3 registers.
    logic               r3_vld;
    logic [61:0]        r3_cos2;
    logic [CW-1:0]      r3_cos;
    logic [SDENW-1:0]   r3_n1sq, r3_n2sq, r3_dsq;
    logic [RDENW-1:0]   r3_ssq;
    logic               r3_zero, r3_gt;
    // Stage 4 registers.
    logic               r4_vld;
    logic [NUMW-1:0]    r4_num;
    logic [SDENW-1:0]   r4_n2sq, r4_dsq;
    logic [RDENW-1:0]   r4_ssq;
    logic [CW-1:0]      r4_cos;
    logic               r4_zero, r4_gt;
    // Stage 5 registers.
    logic               r5_vld;
    t_frt               r5_side;
    logic [NUMW-1:0]    r5_num;
    logic [SDENW-1:0]   r5_n2sq, r5_dsq;
    logic [RDENW-1:0]   r5_ssq;

    logic signed [33:0] n_dot;
    logic [28:0]        n_dotc;
    logic [CW-1:0]      n_omc;
    logic [61:0]        n_omc_full;
    logic               n_tir;

    assign n_dot = 34'(r1_px) + 34'(r1_py) + 34'(r1_pz);

    // Clamp the exact Q.28 dot product to 0..1.
    always_comb begin
        if (n_dot[33]) begin
            n_dotc = '0;
        end else if (n_dot > DOT_ONE) begin
            n_dotc = 29'h1000_0000;
        end else begin
            n_dotc = n_dot[28:0];
        end
    end

    assign n_omc_full = ONE_Q60 - r3_cos2;
    assign n_omc      = n_omc_full[60:30];
    assign n_tir      = r4_num > {r4_n2sq, 30'b0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
            r5_vld <= 1'b0;
        end else begin
            r1_vld <= i_vld;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
            r5_vld <= r4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_px   <= i_eye_x * i_normal_x;
        r1_py   <= i_eye_y * i_normal_y;
        r1_pz   <= i_eye_z * i_normal_z;
        r1_n1   <= i_index_from;
        r1_n2   <= i_index_to;
        r1_zero <= (i_index_from == 16'd0) || (i_index_to == 16'd0);
        r1_gt   <= i_index_from > i_index_to;
        r1_d    <= (i_index_from > i_index_to) ? (i_index_from - i_index_to)
                                               : (i_index_to - i_index_from);
        r1_s    <= 17'(i_index_from) + 17'(i_index_to);

        r2_cos  <= {n_dotc, 2'b00};
        r2_n1   <= r1_n1;
        r2_n2   <= r1_n2;
        r2_zero <= r1_zero;
        r2_gt   <= r1_gt;
        r2_dsq  <= SDENW'(r1_d) * SDENW'(r1_d);
        r2_ssq  <= RDENW'(r1_s) * RDENW'(r1_s);

        r3_cos2 <= 62'(r2_cos) * 62'(r2_cos);
        r3_cos  <= r2_cos;
        r3_n1sq <= SDENW'(r2_n1) * SDENW'(r2_n1);
        r3_n2sq <= SDENW'(r2_n2) * SDENW'(r2_n2);
        r3_dsq  <= r2_dsq;
        r3_ssq  <= r2_ssq;
        r3_zero <= r2_zero;
        r3_gt   <= r2_gt;

        r4_num  <= NUMW'(NUMW'(r3_n1sq) * NUMW'(n_omc));
        r4_n2sq <= r3_n2sq;
        r4_dsq  <= r3_dsq;
        r4_ssq  <= r3_ssq;
        r4_cos  <= r3_cos;
        r4_zero <= r3_zero;
        r4_gt   <= r3_gt;

        r5_side.flag <= r4_zero || (r4_gt && n_tir);
        r5_side.gt   <= r4_gt;
        r5_side.cosv <= r4_cos;
        r5_num       <= r4_num;
        r5_n2sq      <= r4_n2sq;
        r5_dsq       <= r4_dsq;
        r5_ssq       <= r4_ssq;
    end

    assign o_vld  = r5_vld;
    assign o_side = r5_side;
    assign o_snum = r5_num;
    assign o_sden = r5_n2sq;
    assign o_rnum = {r5_dsq, 30'b0};
    assign o_rden = r5_ssq;

endmodule

/* hdl/sfr_div.sv */
// Two restoring dividers in lockstep, one quotient bit per stage:
// sin^2 = num / n2^2 and r0 = (d^2 << 30) / s^2. Uses sfr_pkg.
module sfr_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_vld,
    input  sfr_pkg::t_frt             i_side,
    input  logic [sfr_pkg::NUMW-1:0]  i_snum,
    input  logic [sfr_pkg::SDENW-1:0] i_sden,
    input  logic [sfr_pkg::NUMW-1:0]  i_rnum,
    input  logic [sfr_pkg::RDENW-1:0] i_rden,
    output logic                      o_vld,
    output sfr_pkg::t_frt             o_side,
    output logic [sfr_pkg::QW-1:0]    o_sin2,
    output logic [sfr_pkg::QW-1:0]    o_r0
);
    import sfr_pkg::*;

    localparam int RW = RDENW + QW;

    logic             r_vld  [QW];
    t_frt             r_side [QW];
    logic [NUMW-1:0]  r_srem [QW];
    logic [NUMW-1:0]  r_rrem [QW];
    logic [SDENW-1:0] r_sden [QW];
    logic [RDENW-1:0] r_rden [QW];
    logic [QW-1:0]    r_sq   [QW];
    logic [QW-1:0]    r_rq   [QW];

    genvar k;
    generate
        for (k = 0; k < QW; k++) begin : g_stg
            localparam int Bit = QW - 1 - k;
            logic             a_vld;
            t_frt             a_side;
            logic [NUMW-1:0]  a_srem, a_rrem;
            logic [SDENW-1:0] a_sden;
            logic [RDENW-1:0] a_rden;
            logic [QW-1:0]    a_sq, a_rq;
            logic [RW-1:0]    c_strial, c_rtrial;
            logic             c_sge, c_rge;

            if (k == 0) begin : g_in
                assign a_vld  = i_vld;
                assign a_side = i_side;
                assign a_srem = i_snum;
                assign a_rrem = i_rnum;
                assign a_sden = i_sden;
                assign a_rden = i_rden;
                assign a_sq   = '0;
                assign a_rq   = '0;
            end else begin : g_mid
                assign a_vld  = r_vld[k-1];
                assign a_side = r_side[k-1];
                assign a_srem = r_srem[k-1];
                assign a_rrem = r_rrem[k-1];
                assign a_sden = r_sden[k-1];
                assign a_rden = r_rden[k-1];
                assign a_sq   = r_sq[k-1];
                assign a_rq   = r_rq[k-1];
            end

            assign c_strial = RW'(a_sden) << Bit;
            assign c_rtrial = RW'(a_rden) << Bit;
            assign c_sge    = RW'(a_srem) >= c_strial;
            assign c_rge    = RW'(a_rrem) >= c_rtrial;

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[k] <= 1'b0;
                end else begin
                    r_vld[k] <= a_vld;
                end
            end

            always_ff @(posedge i_clk) begin
                r_side[k] <= a_side;
                r_sden[k] <= a_sden;
                r_rden[k] <= a_rden;
                if (c_sge) begin
                    r_srem[k] <= NUMW'(RW'(a_srem) - c_strial);
                    r_sq[k]   <= a_sq | (QW'(1) << Bit);
                end else begin
                    r_srem[k] <= a_srem;
                    r_sq[k]   <= a_sq;
                end
                if (c_rge) begin
                    r_rrem[k] <= NUMW'(RW'(a_rrem) - c_rtrial);
                    r_rq[k]   <= a_rq | (QW'(1) << Bit);
                end else begin
                    r_rrem[k] <= a_rrem;
                    r_rq[k]   <= a_rq;
                end
            end
        end
    endgenerate

    assign o_vld  = r_vld[QW-1];
    assign o_side = r_side[QW-1];
    assign o_sin2 = r_sq[QW-1];
    assign o_r0   = r_rq[QW-1];

endmodule

/* hdl/sfr_sqrt.sv */
// Pipelined digit-by-digit integer square root of (1 - sin^2) in Q.60,
// one result bit per stage. Uses sfr_pkg.
module sfr_sqrt (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_vld,
    input  sfr_pkg::t_sqt          i_side,
    input  logic [sfr_pkg::CW-1:0] i_sin2,
    output logic                   o_vld,
    output sfr_pkg::t_sqt          o_side,
    output logic [sfr_pkg::CW-1:0] o_root
);
    import sfr_pkg::*;

    localparam int RW = 2 * CW;

    logic          r_vld  [CW];
    t_sqt          r_side [CW];
    logic [RW-1:0] r_rem  [CW];
    logic [CW-1:0] r_root [CW];

    logic [CW-1:0] c_omsin;

    assign c_omsin = ONE_Q30 - i_sin2;

    genvar k;
    generate
        for (k = 0; k < CW; k++) begin : g_stg
            localparam int Bit = CW - 1 - k;
            logic          a_vld;
            t_sqt          a_side;
            logic [RW-1:0] a_rem;
            logic [CW-1:0] a_root;
            logic [RW-1:0] c_trial;
            logic          c_ge;

            if (k == 0) begin : g_in
                assign a_vld  = i_vld;
                assign a_side = i_side;
                assign a_rem  = RW'(c_omsin) << FRAC;
                assign a_root = '0;
            end else begin : g_mid
                assign a_vld  = r_vld[k-1];
                assign a_side = r_side[k-1];
                assign a_rem  = r_rem[k-1];
                assign a_root = r_root[k-1];
            end

            assign c_trial = (RW'(a_root) << (Bit + 1)) | (RW'(1) << (2 * Bit));
            assign c_ge    = a_rem >= c_trial;

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[k] <= 1'b0;
                end else begin
                    r_vld[k] <= a_vld;
                end
            end

            always_ff @(posedge i_clk) begin
                r_side[k] <= a_side;
                if (c_ge) begin
                    r_rem[k]  <= a_rem - c_trial;
                    r_root[k] <= a_root | (CW'(1) << Bit);
                end else begin
                    r_rem[k]  <= a_rem;
                    r_root[k] <= a_root;
                end
            end
        end
    endgenerate

    assign o_vld  = r_vld[CW-1];
    assign o_side = r_side[CW-1];
    assign o_root = r_root[CW-1];

endmodule

/* hdl/sfr_back.sv */
// Back end: (1-cos)^5 by four registered multiplies, blend with r0,
// round to Q1.15 and saturate. Six register stages. Uses sfr_pkg.
module sfr_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_vld,
    input  logic                   i_flag,
    input  logic [sfr_pkg::CW-1:0] i_cosv,
    input  logic [sfr_pkg::CW-1:0] i_r0,
    output logic                   o_valid,
    output logic [15:0]            o_reflectance,
    output logic                   o_total_internal
);
    import sfr_pkg::*;

    localparam int NMUL = 4;

    logic          r_vld  [NMUL];
    logic          r_flag [NMUL];
    logic [CW-1:0] r_r0   [NMUL];
    logic [CW-1:0] r_x    [NMUL];
    logic [CW-1:0] r_p    [NMUL];

    logic          r_bvld, r_bflag;
    logic [CW-1:0] r_br0, r_m;
    logic          r_ovld, r_oflag;
    logic [15:0]   r_orefl;

    logic [CW-1:0] c_x0;
    logic [61:0]   c_blend;
    logic [31:0]   c_res;
    logic [16:0]   c_q;

    assign c_x0 = ONE_Q30 - i_cosv;

    genvar k;
    generate
        for (k = 0; k < NMUL; k++) begin : g_mul
            logic          a_vld, a_flag;
            logic [CW-1:0] a_r0, a_x, a_p;
            logic [61:0]   c_prod;

            if (k == 0) begin : g_in
                assign a_vld  = i_vld;
                assign a_flag = i_flag;
                assign a_r0   = i_r0;
                assign a_x    = c_x0;
                assign a_p    = c_x0;
            end else begin : g_mid
                assign a_vld  = r_vld[k-1];
                assign a_flag = r_flag[k-1];
                assign a_r0   = r_r0[k-1];
                assign a_x    = r_x[k-1];
                assign a_p    = r_p[k-1];
            end

            assign c_prod = 62'(a_p) * 62'(a_x);

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[k] <= 1'b0;
                end else begin
                    r_vld[k] <= a_vld;
                end
            end

            always_ff @(posedge i_clk) begin
                r_flag[k] <= a_flag;
                r_r0[k]   <= a_r0;
                r_x[k]    <= a_x;
                r_p[k]    <= c_prod[60:30];
            end
        end
    endgenerate

    assign c_blend = 62'(ONE_Q30 - r_r0[NMUL-1]) * 62'(r_p[NMUL-1]);
    assign c_res   = 32'(r_br0) + 32'(r_m) + 32'd16384;
    assign c_q     = c_res[31:15];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bvld <= 1'b0;
            r_ovld <= 1'b0;
        end else begin
            r_bvld <= r_vld[NMUL-1];
            r_ovld <= r_bvld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bflag <= r_flag[NMUL-1];
        r_br0   <= r_r0[NMUL-1];
        r_m     <= c_blend[60:30];
        r_oflag <= r_bflag;
        if (r_bflag || (c_q > 17'(ONE_Q15))) begin
            r_orefl <= ONE_Q15;
        end else begin
            r_orefl <= c_q[15:0];
        end
    end

    assign o_valid          = r_ovld;
    assign o_reflectance    = r_orefl;
    assign o_total_internal = r_oflag;

endmodule
